// File: rtl/pics_pkg.sv
// Package for the per-thread inlier count stop block.
// Holds the widths, codes and the command and status structs shared by
// the controller, the datapath and the top level. No dependencies.
package pics_pkg;

   localparam int THREADS = 8;
   localparam int THR_W = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int CNT_W = 16;
   localparam int IDX_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_END = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BELOW_PAR_CUTOFF = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_POINTS = 1'b1;

   typedef struct packed {
      logic update;
      logic mul;
      logic sweep;
      logic [THR_W-1:0] sweep_idx;
      logic load_rsp;
      logic stop_sel;
   } cmd_type;

   typedef struct packed {
      logic thread_valid;
   } status_type;

endpackage

// File: rtl/per_thread_inlier_count_stop.sv
// Per-thread inlier count early stop, top level.
// Observe item: counter update, product stage, compare, result register;
// compare waits while a stalled result is held, out-of-range threads skip
// to the result. End item: one counter per cycle through the max sweep.
// Synchronous active-high reset clears all counters and the best count,
// sets below_par_cutoff to 0 and total_points to 65535.
module per_thread_inlier_count_stop (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [pics_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pics_pkg::CNT_W-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_func,
   input  logic [pics_pkg::IDX_W-1:0] req_thread_index,
   input  logic req_is_inlier,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_stop_now,
   output logic [pics_pkg::CNT_W-1:0] rsp_best_inliers
);

   pics_pkg::cmd_type cmd;
   pics_pkg::status_type status;

   assign csr_ready = 1'b1;

   pics_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status(status),
      .cmd(cmd)
   );

   pics_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_thread_index(req_thread_index),
      .req_is_inlier(req_is_inlier),
      .cmd(cmd),
      .status(status),
      .rsp_stop_now(rsp_stop_now),
      .rsp_best_inliers(rsp_best_inliers)
   );

endmodule

// File: rtl/pics_ctrl.sv
// Controller for the per-thread inlier count stop block.
// Sequences observe and end items, owns the handshakes and the sweep
// counter. Depends on pics_pkg.
module pics_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_func,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  pics_pkg::status_type status,
   output pics_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_CMP   = 5'b00100,
      S_SWEEP = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [pics_pkg::THR_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      cmd = '0;
      cmd.sweep_idx = sweep_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == pics_pkg::FUNC_END) begin
                  sweep_cnt_in = '0;
                  state_in = S_SWEEP;
               end else if (status.thread_valid) begin
                  cmd.update = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               cmd.stop_sel = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == pics_pkg::THR_W'(pics_pkg::THREADS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_end_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == pics_pkg::FUNC_END) |=> (state_ff == S_SWEEP))
      else $error("end item did not start the counter sweep");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over an item still waiting");

   a_sweep_from_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && $past(state_ff) == S_IDLE) |-> (sweep_cnt_ff == '0))
      else $error("sweep did not start at thread zero");

endmodule

// File: rtl/pics_dpath.sv
// Datapath for the per-thread inlier count stop block.
// Holds the per-thread counters, best count, configuration, the product
// pipeline and the result register. Depends on pics_pkg.
module pics_dpath (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [pics_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pics_pkg::CNT_W-1:0] csr_data,
   input  logic [pics_pkg::IDX_W-1:0] req_thread_index,
   input  logic req_is_inlier,
   input  pics_pkg::cmd_type cmd,
   output pics_pkg::status_type status,
   output logic rsp_stop_now,
   output logic [pics_pkg::CNT_W-1:0] rsp_best_inliers
);

   localparam int W = pics_pkg::CNT_W;

   logic [W-1:0] points_ff [pics_pkg::THREADS];
   logic [W-1:0] points_in [pics_pkg::THREADS];
   logic [W-1:0] inliers_ff [pics_pkg::THREADS];
   logic [W-1:0] inliers_in [pics_pkg::THREADS];
   logic [W-1:0] best_ff, best_in;
   logic [W-1:0] cutoff_ff, cutoff_in;
   logic [W-1:0] total_ff, total_in;

   logic [W-1:0] p_q_ff, p_q_in;
   logic [W-1:0] i_q_ff, i_q_in;
   logic outlier_ff, outlier_in;
   logic [2*W:0] lhs_ff, lhs_in;
   logic [2*W-1:0] rhs_ff, rhs_in;
   logic reach_ff, reach_in;
   logic stop_ff, stop_in;
   logic [W-1:0] rsp_best_ff, rsp_best_in;

   logic [pics_pkg::THR_W-1:0] thr;
   logic [W-1:0] p_cur, i_cur, p_new, i_new, sweep_val;
   logic [W:0] slack_sum;
   logic stop_calc;

   assign status.thread_valid = (32'(req_thread_index) < pics_pkg::THREADS);
   assign thr = req_thread_index[pics_pkg::THR_W-1:0];
   assign p_cur = points_ff[thr];
   assign i_cur = inliers_ff[thr];
   assign p_new = (p_cur == pics_pkg::CNT_MAX) ? p_cur : p_cur + 1'b1;
   assign i_new = (req_is_inlier && i_cur != pics_pkg::CNT_MAX) ? i_cur + 1'b1 : i_cur;
   assign sweep_val = inliers_ff[cmd.sweep_idx];
   assign slack_sum = {1'b0, i_q_ff} + {1'b0, cutoff_ff};
   assign stop_calc = outlier_ff && (({1'b0, rhs_ff} > lhs_ff) || reach_ff);

   always_comb begin
      points_in = points_ff;
      inliers_in = inliers_ff;
      best_in = best_ff;
      cutoff_in = cutoff_ff;
      total_in = total_ff;
      p_q_in = p_q_ff;
      i_q_in = i_q_ff;
      outlier_in = outlier_ff;
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      reach_in = reach_ff;
      stop_in = stop_ff;
      rsp_best_in = rsp_best_ff;

      if (csr_valid) begin
         case (csr_index)
            pics_pkg::CSR_BELOW_PAR_CUTOFF: cutoff_in = csr_data;
            pics_pkg::CSR_TOTAL_POINTS: total_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.update) begin
         points_in[thr] = p_new;
         inliers_in[thr] = i_new;
         p_q_in = p_new;
         i_q_in = i_new;
         outlier_in = !req_is_inlier;
      end

      if (cmd.mul) begin
         lhs_in = {{W{1'b0}}, slack_sum} * {{(W+1){1'b0}}, total_ff};
         rhs_in = {{W{1'b0}}, best_ff} * {{W{1'b0}}, p_q_ff};
         // Remaining points short of the best: total - p < best - i.
         reach_in = ({1'b0, total_ff} + {1'b0, i_q_ff}) < ({1'b0, best_ff} + {1'b0, p_q_ff});
      end

      if (cmd.sweep) begin
         if (sweep_val > best_ff) begin
            best_in = sweep_val;
         end
         points_in[cmd.sweep_idx] = '0;
         inliers_in[cmd.sweep_idx] = '0;
      end

      if (cmd.load_rsp) begin
         stop_in = cmd.stop_sel ? stop_calc : 1'b0;
         rsp_best_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pics_pkg::THREADS; k++) begin
            points_ff[k] <= '0;
            inliers_ff[k] <= '0;
         end
         best_ff <= '0;
         cutoff_ff <= '0;
         total_ff <= pics_pkg::CNT_MAX;
      end else begin
         points_ff <= points_in;
         inliers_ff <= inliers_in;
         best_ff <= best_in;
         cutoff_ff <= cutoff_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      p_q_ff <= p_q_in;
      i_q_ff <= i_q_in;
      outlier_ff <= outlier_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
      reach_ff <= reach_in;
      stop_ff <= stop_in;
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_stop_now = stop_ff;
   assign rsp_best_inliers = rsp_best_ff;

   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (best_ff >= $past(best_ff)))
      else $error("best count decreased");

endmodule
